// File: hw/rtl/pimsc_pkg.sv
package pimsc_pkg;

  // One input beat: a control tick or a reset command.
  typedef struct packed {
    logic               func;
    logic [31:0]        now_ms;
    logic signed [19:0] actual_speed;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic       drive_written;
    logic [7:0] pwm_duty;
    logic       forward;
    logic       dir_line_a;
    logic       dir_line_b;
  } out_item_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_TARGET_SPEED = 3'd0,
    CFG_KP_GAIN      = 3'd1,
    CFG_KI_GAIN      = 3'd2,
    CFG_INTERVAL     = 3'd3,
    CFG_INVERT       = 3'd4
  } cfg_idx_t;

  localparam int unsigned CfgDataW = 20;

  // Function codes of an input beat.
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_RESET = 1'b1;

  // Register reset values.
  localparam logic signed [19:0] TARGET_RST   = 20'sd0;
  localparam logic [15:0]        KP_RST       = 16'd256;
  localparam logic [15:0]        KI_RST       = 16'd26;
  localparam logic [9:0]         INTERVAL_RST = 10'd15;

  // Arithmetic constants.
  localparam logic [31:0]        STALE_MS   = 32'd100;
  localparam logic signed [28:0] INT_LIMIT  = 29'sd100000;
  localparam logic signed [17:0] MUL_1000   = 18'sd1000;
  // floor(q / 125) == (q * 33555) >> 22 for every q below 2^15
  localparam logic signed [17:0] RECIP_125  = 18'sd33555;
  localparam int unsigned        RecipShift = 22;
  // 255 * 256000: the largest magnitude that does not saturate the duty
  localparam logic [47:0]        SAT_LIMIT  = 48'd65280000;
  localparam logic [7:0]         PWM_MAX    = 8'd255;

  // Microcode.
  typedef logic [3:0] uc_step_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ERR_EL,
    MUL_ERR_K1000,
    MUL_CAND_KI,
    MUL_E1000_KP,
    MUL_Q_RECIP
  } mul_op_t;

  typedef enum logic [1:0] {
    SUM_HOLD,
    SUM_LOAD,
    SUM_ADD
  } sum_op_t;

  typedef struct packed {
    mul_op_t  mul_op;
    logic     ld_cand;
    logic     ld_err1000;
    sum_op_t  sum_op;
    logic     ld_mag;
    logic     ld_sat;
    logic     check;
    logic     finish;
    uc_step_t jmp_target;
  } uc_word_t;

  localparam uc_step_t STEP_FINISH = 4'd8;

  function automatic uc_word_t uc_rom(input uc_step_t step);
    uc_word_t w;
    w = '{mul_op: MUL_NONE, ld_cand: 1'b0, ld_err1000: 1'b0, sum_op: SUM_HOLD,
          ld_mag: 1'b0, ld_sat: 1'b0, check: 1'b0, finish: 1'b0,
          jmp_target: STEP_FINISH};
    unique case (step)
      4'd0: w.check = 1'b1;                       // rate limit, error, elapsed
      4'd1: w.mul_op = MUL_ERR_EL;                // err * elapsed
      4'd2: begin                                 // clamp candidate, err * 1000
        w.ld_cand = 1'b1;
        w.mul_op  = MUL_ERR_K1000;
      end
      4'd3: begin                                 // keep err*1000, ki * cand
        w.ld_err1000 = 1'b1;
        w.mul_op     = MUL_CAND_KI;
      end
      4'd4: begin                                 // sum = ki*cand, kp * err*1000
        w.sum_op = SUM_LOAD;
        w.mul_op = MUL_E1000_KP;
      end
      4'd5: w.sum_op = SUM_ADD;
      4'd6: w.ld_mag = 1'b1;                      // magnitude and sign
      4'd7: begin                                 // saturation, divide by 256000
        w.ld_sat = 1'b1;
        w.mul_op = MUL_Q_RECIP;
      end
      default: w.finish = 1'b1;
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/pi_motor_speed_controller.sv
// Channel  Direction  Payload                    Handshake
// in       input      pimsc_pkg::in_item_t       in_valid / in_stall
// out      output     pimsc_pkg::out_item_t      out_valid / out_stall
// cfg      input      cfg_index, cfg_data        cfg_we
//
// Each beat is worked by a nine-step microprogram over one shared 32 x 18 bit
// multiplier; the multiplier and the step counter set the rate.
// A tick that writes a drive runs every step; a reset command or a skipped tick
// jumps from the check step to the final step. The input stalls until the final step.
// The result sits in an output register, so a new beat is taken while it waits;
// the final step holds while that register is still full and stalled.
// Reset (rst, synchronous) restores the register defaults and clears the
// integral and the last-update time.
module pi_motor_speed_controller (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  pimsc_pkg::in_item_t          in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output pimsc_pkg::out_item_t         out_data,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [pimsc_pkg::CfgDataW-1:0] cfg_data
);

  // Configuration registers.
  logic signed [19:0] target_speed;
  logic [15:0]        kp_gain;
  logic [15:0]        ki_gain;
  logic [9:0]         update_interval_ms;
  logic               invert_direction;

  // Controller state.
  logic signed [17:0] integral_acc;
  logic [31:0]        last_time;

  // Sequencer and datapath registers.
  logic                busy;
  pimsc_pkg::uc_step_t step;
  pimsc_pkg::uc_step_t step_next;
  pimsc_pkg::uc_word_t uw;
  pimsc_pkg::in_item_t item;
  logic                no_drive;
  logic signed [20:0]  err;
  logic [6:0]          elapsed;
  logic signed [17:0]  cand;
  logic signed [30:0]  err1000;
  logic signed [47:0]  prod;
  logic signed [48:0]  sum;
  logic [47:0]         mag;
  logic                fwd;
  logic                sat;

  logic                in_take;
  logic                out_free;
  logic                finishing;

  // Combinational datapath.
  logic [31:0]         elapsed_full;
  logic                skip;
  logic signed [31:0]  mul_a;
  logic signed [17:0]  mul_b;
  logic signed [49:0]  mul_p;
  logic signed [28:0]  cand_sum;
  logic signed [17:0]  cand_clamped;
  logic signed [48:0]  sum_abs;
  logic [7:0]          pwm;
  logic                eff;

  assign uw        = pimsc_pkg::uc_rom(step);
  assign in_stall  = busy;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign finishing = busy && uw.finish && out_free;

  // Rate limit: a reset command, a first tick, a tick too soon and a stale tick
  // all end without a drive.
  assign elapsed_full = item.now_ms - last_time;
  assign skip = (item.func == pimsc_pkg::FUNC_RESET) || (last_time == 32'd0) ||
                (elapsed_full < {22'd0, update_interval_ms}) ||
                (elapsed_full > pimsc_pkg::STALE_MS);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (uw.mul_op)
      pimsc_pkg::MUL_ERR_EL: begin
        mul_a = {{11{err[20]}}, err};
        mul_b = {11'd0, elapsed};
      end
      pimsc_pkg::MUL_ERR_K1000: begin
        mul_a = {{11{err[20]}}, err};
        mul_b = pimsc_pkg::MUL_1000;
      end
      pimsc_pkg::MUL_CAND_KI: begin
        mul_a = {{14{cand[17]}}, cand};
        mul_b = {2'b00, ki_gain};
      end
      pimsc_pkg::MUL_E1000_KP: begin
        mul_a = {err1000[30], err1000};
        mul_b = {2'b00, kp_gain};
      end
      pimsc_pkg::MUL_Q_RECIP: begin
        mul_a = {17'd0, mag[25:11]};
        mul_b = pimsc_pkg::RECIP_125;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Candidate integral: the stored value plus err * elapsed, held to the limit.
  assign cand_sum = {{11{integral_acc[17]}}, integral_acc} + prod[28:0];
  always_comb begin
    priority if (cand_sum > pimsc_pkg::INT_LIMIT) begin
      cand_clamped = pimsc_pkg::INT_LIMIT[17:0];
    end else if (cand_sum < -pimsc_pkg::INT_LIMIT) begin
      cand_clamped = 18'(-pimsc_pkg::INT_LIMIT);
    end else begin
      cand_clamped = cand_sum[17:0];
    end
  end

  assign sum_abs = sum[48] ? -sum : sum;
  // After the reciprocal multiply, prod holds floor(mag / 256000) in its upper bits.
  assign pwm     = sat ? pimsc_pkg::PWM_MAX : prod[pimsc_pkg::RecipShift +: 8];
  assign eff     = fwd ^ invert_direction;

  // Step counter: the check step jumps to the final step when no drive is due.
  always_comb begin
    priority if (uw.check && skip) begin
      step_next = uw.jmp_target;
    end else if (uw.finish) begin
      step_next = out_free ? 4'd0 : step;
    end else begin
      step_next = step + 4'd1;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_speed       <= pimsc_pkg::TARGET_RST;
      kp_gain            <= pimsc_pkg::KP_RST;
      ki_gain            <= pimsc_pkg::KI_RST;
      update_interval_ms <= pimsc_pkg::INTERVAL_RST;
      invert_direction   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pimsc_pkg::CFG_TARGET_SPEED: target_speed       <= cfg_data;
        pimsc_pkg::CFG_KP_GAIN:      kp_gain            <= cfg_data[15:0];
        pimsc_pkg::CFG_KI_GAIN:      ki_gain            <= cfg_data[15:0];
        pimsc_pkg::CFG_INTERVAL:     update_interval_ms <= cfg_data[9:0];
        pimsc_pkg::CFG_INVERT:       invert_direction   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer control, controller state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      step         <= '0;
      out_valid    <= 1'b0;
      integral_acc <= '0;
      last_time    <= '0;
    end else begin
      if (in_take) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step_next;
      end

      if (busy && uw.check) begin
        priority if (item.func == pimsc_pkg::FUNC_RESET) begin
          integral_acc <= '0;
          last_time    <= '0;
        end else if (last_time == 32'd0) begin
          last_time <= item.now_ms;
        end else if (elapsed_full >= {22'd0, update_interval_ms}) begin
          last_time <= item.now_ms;
        end else begin
          // A tick that comes too soon leaves the state as it is.
        end
      end

      if (finishing) begin
        busy      <= 1'b0;
        out_valid <= 1'b1;
        if (!no_drive && !sat) begin
          integral_acc <= cand;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= in_data;
    end
    if (busy && uw.check) begin
      no_drive <= skip;
      err      <= {target_speed[19], target_speed} -
                  {item.actual_speed[19], item.actual_speed};
      elapsed  <= elapsed_full[6:0];
      sat      <= 1'b0;
    end
    if (busy && uw.mul_op != pimsc_pkg::MUL_NONE) begin
      prod <= mul_p[47:0];
    end
    if (busy && uw.ld_cand) begin
      cand <= cand_clamped;
    end
    if (busy && uw.ld_err1000) begin
      err1000 <= prod[30:0];
    end
    if (busy) begin
      unique case (uw.sum_op)
        pimsc_pkg::SUM_LOAD: sum <= {prod[47], prod};
        pimsc_pkg::SUM_ADD:  sum <= sum + {prod[47], prod};
        default: ;
      endcase
    end
    if (busy && uw.ld_mag) begin
      mag <= sum_abs[47:0];
      fwd <= !sum[48];
    end
    if (busy && uw.ld_sat) begin
      sat <= mag > pimsc_pkg::SAT_LIMIT;
    end
    if (finishing) begin
      if (no_drive) begin
        out_data <= '0;
      end else begin
        out_data.drive_written <= 1'b1;
        out_data.pwm_duty      <= pwm;
        out_data.forward       <= fwd;
        out_data.dir_line_a    <= !eff;
        out_data.dir_line_b    <= eff;
      end
    end
  end

endmodule

// File: hw/rtl/pimsc_checker.sv
module pimsc_props (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input pimsc_pkg::out_item_t         out_data
);

  // A beat without a drive carries all-zero fields.
  a_no_drive_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.drive_written) |->
      (out_data.pwm_duty == 8'd0 && !out_data.forward &&
       !out_data.dir_line_a && !out_data.dir_line_b))
    else $error("no-drive result carries non-zero fields");

  // A drive always sets the two bridge lines to opposite levels.
  a_dir_opposite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.drive_written) |->
      (out_data.dir_line_a != out_data.dir_line_b))
    else $error("direction lines not complementary");

  // The block works one beat at a time: it stalls right after an acceptance.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a beat was taken");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind pi_motor_speed_controller pimsc_props u_pimsc_props (.*);
